/* src/hsr_pkg.sv */
// Shared types, codes and elaboration helpers for the handle slot registry.
// Used by hsr_ctrl, hsr_dpath and handle_slot_registry_unit; depends on nothing.
package hsr_pkg;

    localparam int MAX_SLOTS_DEF     = 32;
    localparam int INITIAL_SLOTS_DEF = 4;
    localparam int MAX_RESULTS       = 32;
    localparam int NW                = 6;   // holds 0 .. MAX_RESULTS
    localparam int SZW               = 3;   // holds log2 of the active size

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_LOOKUP     = 2'd2,
        CMD_LIST       = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SCAN,
        OP_GROW_RD,
        OP_GROW_WR,
        OP_LK_RD,
        OP_LK_CMP,
        OP_LS_START,
        OP_LS_RD,
        OP_LS_CMP,
        OP_LS_PICK,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_GROW_RD,
        S_GROW_WR,
        S_LK_RD,
        S_LK_CMP,
        S_LS_RD,
        S_LS_CMP,
        S_LS_PICK,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic scan_hit;
        logic scan_end;
        logic at_cap;
        logic idx_end;
        logic res_last;
        logic out_free;
    } dp_stat_t;

    // Log2 of the largest power of two not above max_slots, at most 7.
    function automatic int cap_log2(input int max_slots);
        int l;
        l = 0;
        while (l < 7 && (2 << l) <= max_slots)
            l++;
        return l;
    endfunction

    // Log2 of the largest power of two not above init_slots and the cap.
    function automatic int init_log2(input int init_slots, input int cl);
        int l;
        l = 0;
        while (l < cl && (2 << l) <= init_slots)
            l++;
        return l;
    endfunction

endpackage

/* src/hsr_ctrl.sv */
// Controller state machine of the handle slot registry.
// Depends on hsr_pkg; drives the datapath hsr_dpath through dp_cmd_t.
module hsr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output hsr_pkg::dp_cmd_t  cmd,
    input  hsr_pkg::dp_stat_t stat
);

    hsr_pkg::state_t state_reg;
    hsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hsr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = hsr_pkg::OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            hsr_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = hsr_pkg::OP_LATCH;
                    state_next = hsr_pkg::S_DISPATCH;
                end
            end
            hsr_pkg::S_DISPATCH:
            begin
                unique case (stat.cmd)
                    hsr_pkg::CMD_REGISTER:   state_next = hsr_pkg::S_SCAN;
                    hsr_pkg::CMD_UNREGISTER: state_next = hsr_pkg::S_LK_RD;
                    hsr_pkg::CMD_LOOKUP:     state_next = hsr_pkg::S_LK_RD;
                    hsr_pkg::CMD_LIST:
                    begin
                        cmd.op     = hsr_pkg::OP_LS_START;
                        state_next = hsr_pkg::S_LS_RD;
                    end
                    default:                 state_next = hsr_pkg::S_IDLE;
                endcase
            end
            hsr_pkg::S_SCAN:
            begin
                cmd.op = hsr_pkg::OP_SCAN;
                if (stat.scan_hit)
                    state_next = hsr_pkg::S_EMIT;
                else if (stat.scan_end)
                    state_next = stat.at_cap ? hsr_pkg::S_EMIT : hsr_pkg::S_GROW_RD;
            end
            hsr_pkg::S_GROW_RD:
            begin
                cmd.op     = hsr_pkg::OP_GROW_RD;
                state_next = hsr_pkg::S_GROW_WR;
            end
            hsr_pkg::S_GROW_WR:
            begin
                cmd.op     = hsr_pkg::OP_GROW_WR;
                state_next = stat.idx_end ? hsr_pkg::S_SCAN : hsr_pkg::S_GROW_RD;
            end
            hsr_pkg::S_LK_RD:
            begin
                cmd.op     = hsr_pkg::OP_LK_RD;
                state_next = hsr_pkg::S_LK_CMP;
            end
            hsr_pkg::S_LK_CMP:
            begin
                cmd.op     = hsr_pkg::OP_LK_CMP;
                state_next = hsr_pkg::S_EMIT;
            end
            hsr_pkg::S_LS_RD:
            begin
                cmd.op     = hsr_pkg::OP_LS_RD;
                state_next = hsr_pkg::S_LS_CMP;
            end
            hsr_pkg::S_LS_CMP:
            begin
                cmd.op     = hsr_pkg::OP_LS_CMP;
                state_next = stat.idx_end ? hsr_pkg::S_LS_PICK : hsr_pkg::S_LS_RD;
            end
            hsr_pkg::S_LS_PICK:
            begin
                cmd.op     = hsr_pkg::OP_LS_PICK;
                state_next = hsr_pkg::S_EMIT;
            end
            hsr_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = hsr_pkg::OP_EMIT;
                    state_next = stat.res_last ? hsr_pkg::S_IDLE : hsr_pkg::S_LS_RD;
                end
            end
            default: state_next = hsr_pkg::S_IDLE;
        endcase
    end

endmodule

/* src/hsr_dpath.sv */
// Datapath of the handle slot registry: slot memories, valid bits, counters,
// result and output registers. Depends on hsr_pkg; sequenced by hsr_ctrl.
module hsr_dpath
#(
    parameter int MAX_SLOTS     = hsr_pkg::MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = hsr_pkg::INITIAL_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [63:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  hsr_pkg::dp_cmd_t  cmd,
    output hsr_pkg::dp_stat_t stat
);

    localparam int CAP_LOG2 = hsr_pkg::cap_log2(MAX_SLOTS);
    localparam int IW       = CAP_LOG2;
    localparam int CAP      = 1 << CAP_LOG2;
    localparam int CW       = IW + 1;
    localparam int INIT_L2  = hsr_pkg::init_log2(INITIAL_SLOTS, CAP_LOG2);

    // Slot memories; read data is registered.
    logic [31:0] mem_h [CAP];
    logic [31:0] mem_o [CAP];
    logic [31:0] rd_h_reg;
    logic [31:0] rd_o_reg;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0] wr_h;
    logic [31:0] wr_o;
    logic [IW-1:0] rd_addr;

    logic [CAP-1:0]         valid_reg, valid_next;
    logic [CAP-1:0]         taken_reg, taken_next;
    logic [31:0]            next_id_reg, next_id_next;
    logic [hsr_pkg::SZW-1:0] size_log2_reg, size_log2_next;
    logic [IW-1:0]          i_reg, i_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [hsr_pkg::NW-1:0] n_reg, n_next;
    logic                   best_ok_reg, best_ok_next;
    logic                   first_reg, first_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic [31:0]            best_h_reg, best_h_next;
    logic [31:0]            best_o_reg, best_o_next;
    hsr_pkg::cmd_t          cmd_reg, cmd_next;
    logic [31:0]            hid_reg, hid_next;
    logic [31:0]            own_reg, own_next;
    logic [1:0]             res_st_reg, res_st_next;
    logic [31:0]            res_id_reg, res_id_next;
    logic [31:0]            res_own_reg, res_own_next;
    logic                   res_last_reg, res_last_next;
    logic                   out_v_reg, out_v_next;
    logic [63:0]            out_d_reg, out_d_next;
    logic [1:0]             out_u_reg, out_u_next;
    logic                   out_l_reg, out_l_next;

    logic [IW:0]   size_full;
    logic [IW-1:0] size_m1;
    logic [31:0]   cand_id;
    logic [IW-1:0] cand_h;
    logic [IW-1:0] lk_h;
    logic          scan_hit;
    logic          idx_end;
    logic          at_cap;
    logic          out_free;
    logic [7:0]    tot;
    logic [7:0]    n_plus1;

    assign size_full = (IW + 1)'(1) << size_log2_reg;
    assign size_m1   = IW'(size_full - (IW + 1)'(1));
    assign cand_id   = next_id_reg + 32'(i_reg);
    assign cand_h    = cand_id[IW-1:0] & size_m1;
    assign lk_h      = hid_reg[IW-1:0] & size_m1;
    assign scan_hit  = (cand_id != 32'd0) && !valid_reg[cand_h];
    assign idx_end   = (i_reg == size_m1);
    assign at_cap    = (size_log2_reg >= hsr_pkg::SZW'(CAP_LOG2));
    assign out_free  = !out_v_reg || m_tready;
    assign tot       = (8'(cnt_reg) > 8'(hsr_pkg::MAX_RESULTS)) ?
                       8'(hsr_pkg::MAX_RESULTS) : 8'(cnt_reg);
    assign n_plus1   = 8'(n_reg) + 8'd1;
    assign rd_addr   = (cmd.op == hsr_pkg::OP_LK_RD) ? lk_h : i_reg;

    assign stat.cmd      = cmd_reg;
    assign stat.scan_hit = scan_hit;
    assign stat.scan_end = idx_end;
    assign stat.at_cap   = at_cap;
    assign stat.idx_end  = idx_end;
    assign stat.res_last = res_last_reg;
    assign stat.out_free = out_free;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;
    assign m_tlast  = out_l_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_h[wr_addr] <= wr_h;
            mem_o[wr_addr] <= wr_o;
        end
        rd_h_reg <= mem_h[rd_addr];
        rd_o_reg <= mem_o[rd_addr];
    end

    always_comb
    begin
        valid_next     = valid_reg;
        taken_next     = taken_reg;
        next_id_next   = next_id_reg;
        size_log2_next = size_log2_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        best_ok_next   = best_ok_reg;
        first_next     = first_reg;
        best_idx_next  = best_idx_reg;
        best_h_next    = best_h_reg;
        best_o_next    = best_o_reg;
        cmd_next       = cmd_reg;
        hid_next       = hid_reg;
        own_next       = own_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_own_next   = res_own_reg;
        res_last_next  = res_last_reg;
        out_v_next     = out_v_reg & ~m_tready;
        out_d_next     = out_d_reg;
        out_u_next     = out_u_reg;
        out_l_next     = out_l_reg;
        wr_en          = 1'b0;
        wr_addr        = cand_h;
        wr_h           = cand_id;
        wr_o           = own_reg;

        unique case (cmd.op)
            hsr_pkg::OP_LATCH:
            begin
                cmd_next = hsr_pkg::cmd_t'(s_tuser);
                hid_next = s_tdata[31:0];
                own_next = s_tdata[63:32];
                i_next   = '0;
            end
            hsr_pkg::OP_SCAN:
            begin
                if (scan_hit)
                begin
                    wr_en              = 1'b1;
                    valid_next[cand_h] = 1'b1;
                    next_id_next       = cand_id + 32'd1;
                    res_st_next        = hsr_pkg::ST_OK;
                    res_id_next        = cand_id;
                    res_own_next       = 32'd0;
                    res_last_next      = 1'b1;
                end
                else if (idx_end)
                begin
                    i_next        = '0;
                    res_st_next   = hsr_pkg::ST_FULL;
                    res_id_next   = hid_reg;
                    res_own_next  = 32'd0;
                    res_last_next = 1'b1;
                end
                else
                    i_next = i_reg + IW'(1);
            end
            hsr_pkg::OP_GROW_WR:
            begin
                // An entry whose new index bit is set moves up by the old size.
                wr_addr = i_reg + size_full[IW-1:0];
                wr_h    = rd_h_reg;
                wr_o    = rd_o_reg;
                if (valid_reg[i_reg] && rd_h_reg[size_log2_reg])
                begin
                    wr_en               = 1'b1;
                    valid_next[wr_addr] = 1'b1;
                    valid_next[i_reg]   = 1'b0;
                end
                if (idx_end)
                begin
                    size_log2_next = size_log2_reg + hsr_pkg::SZW'(1);
                    i_next         = '0;
                end
                else
                    i_next = i_reg + IW'(1);
            end
            hsr_pkg::OP_LK_CMP:
            begin
                res_id_next   = hid_reg;
                res_last_next = 1'b1;
                if (valid_reg[lk_h] && rd_h_reg == hid_reg)
                begin
                    res_st_next  = hsr_pkg::ST_OK;
                    res_own_next = rd_o_reg;
                    if (cmd_reg == hsr_pkg::CMD_UNREGISTER)
                        valid_next[lk_h] = 1'b0;
                end
                else
                begin
                    res_st_next  = hsr_pkg::ST_MISS;
                    res_own_next = 32'd0;
                end
            end
            hsr_pkg::OP_LS_START:
            begin
                taken_next   = '0;
                cnt_next     = '0;
                n_next       = '0;
                best_ok_next = 1'b0;
                first_next   = 1'b1;
                i_next       = '0;
            end
            hsr_pkg::OP_LS_CMP:
            begin
                if (first_reg && valid_reg[i_reg])
                    cnt_next = cnt_reg + CW'(1);
                if (valid_reg[i_reg] && !taken_reg[i_reg] &&
                    (!best_ok_reg || rd_h_reg < best_h_reg))
                begin
                    best_ok_next  = 1'b1;
                    best_idx_next = i_reg;
                    best_h_next   = rd_h_reg;
                    best_o_next   = rd_o_reg;
                end
                i_next = idx_end ? '0 : i_reg + IW'(1);
            end
            hsr_pkg::OP_LS_PICK:
            begin
                if (best_ok_reg)
                begin
                    res_st_next              = hsr_pkg::ST_OK;
                    res_id_next              = best_h_reg;
                    res_own_next             = best_o_reg;
                    res_last_next            = (n_plus1 == tot);
                    taken_next[best_idx_reg] = 1'b1;
                    n_next                   = n_reg + hsr_pkg::NW'(1);
                end
                else
                begin
                    res_st_next   = hsr_pkg::ST_MISS;
                    res_id_next   = 32'd0;
                    res_own_next  = 32'd0;
                    res_last_next = 1'b1;
                end
            end
            hsr_pkg::OP_EMIT:
            begin
                out_v_next   = 1'b1;
                out_d_next   = {res_own_reg, res_id_reg};
                out_u_next   = res_st_reg;
                out_l_next   = res_last_reg;
                best_ok_next = 1'b0;
                first_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            taken_reg     <= '0;
            next_id_reg   <= 32'd1;
            size_log2_reg <= hsr_pkg::SZW'(INIT_L2);
            i_reg         <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            best_ok_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_v_reg     <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            taken_reg     <= taken_next;
            next_id_reg   <= next_id_next;
            size_log2_reg <= size_log2_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            best_ok_reg   <= best_ok_next;
            first_reg     <= first_next;
            out_v_reg     <= out_v_next;
            res_last_reg  <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_h_reg   <= best_h_next;
        best_o_reg   <= best_o_next;
        cmd_reg      <= cmd_next;
        hid_reg      <= hid_next;
        own_reg      <= own_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_own_reg  <= res_own_next;
        out_d_reg    <= out_d_next;
        out_u_reg    <= out_u_next;
        out_l_reg    <= out_l_next;
    end

endmodule

/* src/handle_slot_registry_unit.sv */
// Handle slot registry: register scans candidate ids and rehashes every slot on each
// table growth; lookup reads one slot; list makes a pass over all slots per entry listed.
// One item is in work at a time; the next is taken once its last result sits in
// the output register. The scan and the slot memories (one read, one write port) set the rate.
// Asynchronous active-low reset clears all valid bits, next id to one and the
// table to its initial size; no clearing pass is needed.
module handle_slot_registry_unit
#(
    parameter int MAX_SLOTS     = hsr_pkg::MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = hsr_pkg::INITIAL_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // handle_id [31:0], owner_tag [63:32]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_id [31:0], result_owner [63:32]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast    // last result of the item
);

    // The controller sequences register scans, growth rehashes, lookups and
    // the selection-sort passes of a list; the datapath holds all storage.
    hsr_pkg::dp_cmd_t  dp_cmd;
    hsr_pkg::dp_stat_t dp_stat;

    hsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    hsr_dpath
    #(
        .MAX_SLOTS     (MAX_SLOTS),
        .INITIAL_SLOTS (INITIAL_SLOTS)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

endmodule

/* verif/hsr_checker.sv */
// Checker for the handle slot registry: watches both streams, predicts every result item.
// Depends on hsr_pkg for the command codes and status values.
module hsr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import hsr_pkg::*;

    localparam int SLOTS     = 32;
    localparam int CAP_LG    = 5;
    localparam int INIT_LG   = 2;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id;
        logic [31:0] owner;
        logic        last;
    } reply_t;

    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_id    [SLOTS];
    logic [31:0] tbl_owner [SLOTS];
    logic [31:0] id_counter;
    int          active_lg;
    reply_t      replies_due [$];

    function automatic reply_t mk(logic [1:0] st, logic [31:0] id, logic [31:0] own,
                                  logic lst);
        reply_t r;
        r.status = st;
        r.id     = id;
        r.owner  = own;
        r.last   = lst;
        return r;
    endfunction

    // Doubles the active size and moves each valid entry under the wider mask.
    task automatic widen_table();
        logic        nv [SLOTS];
        logic [31:0] nh [SLOTS];
        logic [31:0] no [SLOTS];
        int          sz;
        int          h;
        sz = 1 << active_lg;
        for (int i = 0; i < SLOTS; i++)
            nv[i] = 1'b0;
        for (int i = 0; i < sz; i++) begin
            if (tbl_valid[i]) begin
                h = tbl_id[i] & (2 * sz - 1);
                nv[h] = 1'b1;
                nh[h] = tbl_id[i];
                no[h] = tbl_owner[i];
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = nv[i];
            tbl_id[i]    = nh[i];
            tbl_owner[i] = no[i];
        end
        active_lg++;
    endtask

    task automatic predict_registry(logic [1:0] cmd, logic [31:0] hid, logic [31:0] own);
        int          sz;
        int          h;
        int          n;
        int          best;
        logic [31:0] cand;
        logic        done;
        logic        picked [SLOTS];
        sz = 1 << active_lg;
        h  = hid & (sz - 1);
        case (cmd)
            CMD_REGISTER:
            begin
                done = 1'b0;
                while (!done) begin
                    sz = 1 << active_lg;
                    for (int i = 0; i < sz && !done; i++) begin
                        cand = id_counter + i;
                        h    = cand & (sz - 1);
                        if (cand != 0 && !tbl_valid[h]) begin
                            tbl_valid[h] = 1'b1;
                            tbl_id[h]    = cand;
                            tbl_owner[h] = own;
                            id_counter   = cand + 1;
                            replies_due.push_back(mk(ST_OK, cand, '0, 1'b1));
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (active_lg >= CAP_LG) begin
                            replies_due.push_back(mk(ST_FULL, hid, '0, 1'b1));
                            done = 1'b1;
                        end else begin
                            widen_table();
                        end
                    end
                end
            end
            CMD_UNREGISTER, CMD_LOOKUP:
            begin
                if (tbl_valid[h] && tbl_id[h] == hid) begin
                    if (cmd == CMD_UNREGISTER)
                        tbl_valid[h] = 1'b0;
                    replies_due.push_back(mk(ST_OK, hid, tbl_owner[h], 1'b1));
                end else begin
                    replies_due.push_back(mk(ST_MISS, hid, '0, 1'b1));
                end
            end
            default:
            begin
                // Listing walks entries in ascending id order, capped at 32 results.
                n = 0;
                for (int i = 0; i < SLOTS; i++)
                    picked[i] = 1'b0;
                best = 0;
                while (n < MAX_RESULTS && best >= 0) begin
                    best = -1;
                    for (int i = 0; i < sz; i++)
                        if (tbl_valid[i] && !picked[i] &&
                            (best < 0 || tbl_id[i] < tbl_id[best]))
                            best = i;
                    if (best >= 0) begin
                        picked[best] = 1'b1;
                        replies_due.push_back(mk(ST_OK, tbl_id[best], tbl_owner[best],
                                                 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    replies_due.push_back(mk(ST_MISS, '0, '0, 1'b1));
                else
                    replies_due[$].last = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                tbl_valid[i] = 1'b0;
            id_counter = 32'd1;
            active_lg  = INIT_LG;
            replies_due.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = mk(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tlast);
                if (replies_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: status %0d id %h owner %h last %b",
                                 got.status, got.id, got.owner, got.last);
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: expected status %0d id %h owner %h ",
                                      "last %b, got status %0d id %h owner %h last %b"},
                                     want.status, want.id, want.owner, want.last,
                                     got.status, got.id, got.owner, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_registry(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            pending = replies_due.size();
        end
    end

endmodule

/* verif/tb_handle_slot_registry_unit.sv */
// Top of the handle slot registry testbench: clock, reset, stimulus and verdict.
// Depends on hsr_pkg, handle_slot_registry_unit and the hsr_checker module.
module tb_handle_slot_registry_unit;
    import hsr_pkg::*;

    // A full list makes one pass over all slots per entry listed, up to 32 entries; the limit
    // covers every item being that slow under the heaviest stall phase, several times.
    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;      // handle_id [31:0], owner_tag [63:32]
    logic [1:0]  s_tuser;      // cmd [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;      // result_id [31:0], result_owner [63:32]
    logic [1:0]  m_tuser;      // status [1:0]
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          cycles;
    int          send_idle_pct;
    int          sink_stall_pct;
    int          registers_sent;
    logic        item_taken;

    handle_slot_registry_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hsr_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The handshake is captured at the rising edge and read back at the next
    // falling edge, so the driver never races the block's ready update.
    always @(posedge clk)
        item_taken <= s_tvalid && s_tready;

    // The receiver stalls at random with the rate of the current phase.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // A run that hangs is ended here with the failure verdict.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drives one item starting at a falling edge and returns at the falling
    // edge after it was taken, leaving tvalid high for the caller to reuse.
    task automatic send_item(cmd_t cmd, logic [31:0] hid, logic [31:0] own);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {own, hid};
        if (cmd == CMD_REGISTER)
            registers_sent++;
        do
            @(negedge clk);
        while (!item_taken);
    endtask

    // Ids are handed out in rising order, so ids near the number of registers
    // sent so far hit live entries often; a few fully random ids cover all bits.
    function automatic logic [31:0] pick_id();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(registers_sent + 2, 0);
    endfunction

    task automatic random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            send_item(CMD_REGISTER, $urandom, $urandom);
        else if (roll < 62)
            send_item(CMD_UNREGISTER, pick_id(), $urandom);
        else if (roll < 88)
            send_item(CMD_LOOKUP, pick_id(), $urandom);
        else
            send_item(CMD_LIST, $urandom, $urandom);
    endtask

    // Holds the sender off until the block has delivered everything owed.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        cycles         = 0;
        registers_sent = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_REGISTER;
        m_tready       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: an empty list, misses on an empty table, the extreme
        // ids and owners, growth past four slots, unregister and listing.
        send_item(CMD_LIST, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_LOOKUP, 32'd0, 32'd0);
        send_item(CMD_UNREGISTER, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_REGISTER, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_REGISTER, 32'd0, 32'd0);
        send_item(CMD_LOOKUP, 32'd1, 32'h1234_5678);
        send_item(CMD_LOOKUP, 32'd5, 32'd0);
        for (int i = 0; i < 6; i++)
            send_item(CMD_REGISTER, $urandom, 32'h5a5a_0000 + i);
        send_item(CMD_LIST, 32'd0, 32'd0);
        send_item(CMD_UNREGISTER, 32'd2, 32'd0);
        send_item(CMD_UNREGISTER, 32'd2, 32'd0);
        send_item(CMD_LOOKUP, 32'd3, 32'hffff_ffff);
        send_item(CMD_LOOKUP, 32'hffff_fff3, 32'd0);
        // Fill to the slot cap so the table grows to 32 and then reports full.
        for (int i = 0; i < 30; i++)
            send_item(CMD_REGISTER, $urandom, $urandom);
        send_item(CMD_LIST, 32'd0, 32'd0);
        drain();

        // Random part in four pressure phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 71; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin send_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int n = 0; n < 38; n++)
                random_item();
            drain();
        end

        s_tvalid       <= 1'b0;
        sink_stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
